[hw/rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// Modem response matcher package
// Reply word table, word lengths, reply codes and shared types.
// ----------------------------------------------------------------------------
package mrm_pkg;

   localparam int WordCount = 4;
   localparam int CountW    = 4;
   localparam int TextDepth = 1 << CountW;
   localparam int CodeW     = 2;
   localparam int ByteW     = 8;
   localparam int ReqDataW  = 16;
   localparam int RspDataW  = 8;

   typedef logic [ByteW-1:0]  char_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [CodeW-1:0]  code_type;

   localparam code_type CODE_OK        = 2'd0;
   localparam code_type CODE_READY     = 2'd1;
   localparam code_type CODE_FAIL      = 2'd2;
   localparam code_type CODE_NO_CHANGE = 2'd3;

   localparam count_type WordLen [WordCount] = '{4'd2, 4'd5, 4'd4, 4'd9};

   localparam char_type WordText [WordCount][TextDepth] = '{
      '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "a", "d", "y", 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"F", "A", "I", "L", 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "o", " ", "c", "h", "a", "n", "g",
        "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic     matched;
      code_type reply_code;
   } mrm_result_type;

endpackage

[hw/rtl/mrm_match_core.sv]
// ----------------------------------------------------------------------------
// Modem response matcher core
// Holds the per-word match counts and compares one byte against all words.
// ----------------------------------------------------------------------------
module mrm_match_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  mrm_pkg::char_type       rx_byte,
   input  logic                    clear_first,
   output mrm_pkg::mrm_result_type result
);
   import mrm_pkg::*;

   count_type counts_ff [WordCount];
   count_type counts_in [WordCount];
   count_type step_count [WordCount];
   logic      hit;
   code_type  code;

   always_comb begin
      count_type base;
      hit  = 1'b0;
      code = CODE_OK;
      for (int i = 0; i < WordCount; i++) begin
         base = clear_first ? '0 : counts_ff[i];
         if ((base < WordLen[i]) && (WordText[i][base] == rx_byte)) begin
            step_count[i] = base + 1'b1;
            if (step_count[i] == WordLen[i]) begin
               hit  = 1'b1;
               code = code_type'(i);
            end
         end else begin
            step_count[i] = '0;
         end
      end
      for (int i = 0; i < WordCount; i++) begin
         if (!enable) begin
            counts_in[i] = counts_ff[i];
         end else if (hit) begin
            counts_in[i] = '0;
         end else begin
            counts_in[i] = step_count[i];
         end
      end
   end

   assign result.matched    = hit;
   assign result.reply_code = hit ? code : CODE_OK;

   always_ff @(posedge clock) begin
      for (int i = 0; i < WordCount; i++) begin
         if (reset) begin
            counts_ff[i] <= '0;
         end else begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_clear_after_hit : assert property (@(posedge clock) disable iff (reset)
      (enable && hit) |=> ((counts_ff[0] == '0) && (counts_ff[1] == '0) &&
                           (counts_ff[2] == '0) && (counts_ff[3] == '0)))
      else $error("Match counts not cleared after a completed word.");

   a_counts_in_range : assert property (@(posedge clock) disable iff (reset)
      (counts_ff[0] < WordLen[0]) && (counts_ff[1] < WordLen[1]) &&
      (counts_ff[2] < WordLen[2]) && (counts_ff[3] < WordLen[3]))
      else $error("A match count has reached its word length.");

   a_hold_when_idle : assert property (@(posedge clock) disable iff (reset)
      !enable |=> ((counts_ff[0] == $past(counts_ff[0])) &&
                   (counts_ff[3] == $past(counts_ff[3]))))
      else $error("Match counts changed without a transfer.");
`endif

endmodule

[hw/rtl/modem_response_matcher_top.sv]
// ----------------------------------------------------------------------------
// Modem response matcher
// The input register and then the result register lie between a req transfer
// and rsp_tvalid for its result; a low rsp_tready can hold the byte between them.
// Throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when rsp_tready is low.
// Reset: synchronous, active high; clears all match counts and both stages.
// ----------------------------------------------------------------------------
module modem_response_matcher_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0: rx_byte[7:0], clear_first[8], zero padding.
   input  logic [mrm_pkg::ReqDataW-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // Fields from bit 0: matched[0], reply_code[2:1], zero padding.
   output logic [mrm_pkg::RspDataW-1:0] rsp_tdata
);
   import mrm_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   char_type       in_byte_ff;
   logic           in_clear_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   mrm_result_type out_result_ff;
   mrm_result_type core_result;
   logic           advance;
   logic           take_req;

   assign advance  = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take_req = req_tvalid && req_tready;

   assign in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   mrm_match_core u_core (
      .clock       (clock),
      .reset       (reset),
      .enable      (in_valid_ff && advance),
      .rx_byte     (in_byte_ff),
      .clear_first (in_clear_ff),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff  <= req_tdata[ByteW-1:0];
         in_clear_ff <= req_tdata[ByteW];
      end
      if (advance && in_valid_ff) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW-CodeW-1){1'b0}}, out_result_ff.reply_code,
                        out_result_ff.matched};

`ifndef SYNTHESIS
   a_code_zero_unmatched : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_result_ff.matched) |-> (out_result_ff.reply_code == CODE_OK))
      else $error("Reply code set on a result without a match.");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled while the result register is empty.");

   a_item_moves_on : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> rsp_tvalid)
      else $error("Transfer from the input register produced no result.");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Modem response matcher testbench
// Sends received characters into the matcher and checks every reply result
// against a cycle-free model of the four reply word trackers. Directed tests
// cover each word, the naive restart, mid-word clears and extreme bytes.
// A long random stream follows, built mostly from whole, partial and
// corrupted reply words, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   import mrm_pkg::*;

   localparam int ClockHalf     = 5;
   localparam int ResetCycles   = 10;
   localparam int StreamLength  = 1500;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 6;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   string    reply_words [WordCount] = '{"OK", "ready", "FAIL", "no change"};
   code_type reply_codes [WordCount] = '{CODE_OK, CODE_READY, CODE_FAIL, CODE_NO_CHANGE};

   count_type      word_progress [WordCount];
   mrm_result_type expected_replies [$];
   int             replies_seen [WordCount];
   int             chars_sent    = 0;
   int             replies_total = 0;
   int             error_count   = 0;
   bit             req_gaps_on   = 1'b0;
   bit             rsp_stalls_on = 1'b0;
   int             rsp_hold      = 0;

   modem_response_matcher_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #ClockHalf clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 93) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   // A mismatching byte resets a word's progress without being tried as its
   // first character again.
   function automatic mrm_result_type predict_reply(char_type rx_char, logic clr);
      mrm_result_type reply;
      logic           hit;
      code_type       code;
      int             w;
      int             n;
      hit  = 1'b0;
      code = CODE_OK;
      if (clr) begin
         for (w = 0; w < WordCount; w++) word_progress[w] = '0;
      end
      for (w = 0; w < WordCount; w++) begin
         n = word_progress[w];
         if (n < reply_words[w].len() && reply_words[w][n] == rx_char) begin
            word_progress[w] = count_type'(n + 1);
            if (n + 1 == reply_words[w].len()) begin
               hit  = 1'b1;
               code = reply_codes[w];
            end
         end else begin
            word_progress[w] = '0;
         end
      end
      if (hit) begin
         for (w = 0; w < WordCount; w++) word_progress[w] = '0;
      end
      reply.matched    = hit;
      reply.reply_code = hit ? code : CODE_OK;
      return reply;
   endfunction

   task automatic send_char(input char_type rx_char, input logic clr);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataW - ByteW - 1){1'b0}}, clr, rx_char};
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(predict_reply(rx_char, clr));
      chars_sent++;
   endtask

   // Sends the first len characters of a word, optionally with one character
   // replaced by a different byte.
   task automatic send_word_part(input int w, input int len, input logic clr,
                                 input int corrupt_at);
      int       i;
      char_type c;
      for (i = 0; i < len; i++) begin
         c = reply_words[w][i];
         if (i == corrupt_at) begin
            do c = char_type'($urandom_range(0, 255)); while (c == reply_words[w][i]);
         end
         send_char(c, clr && i == 0);
      end
   endtask

   task automatic test_each_reply_word();
      int w;
      for (w = 0; w < WordCount; w++) send_word_part(w, reply_words[w].len(), 1'b1, -1);
   endtask

   task automatic test_naive_restart();
      send_char("O", 1'b1);
      send_char("O", 1'b0);
      send_char("K", 1'b0);
   endtask

   task automatic test_clear_mid_word();
      send_char("O", 1'b0);
      send_char("K", 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
   endtask

   task automatic test_random_stream();
      int chunk;
      int target;
      int w;
      int r;
      int n;
      for (chunk = 1; chunk <= 6; chunk++) begin
         target        = chars_sent + StreamLength / 6;
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on <= $urandom_range(0, 3) != 0;
         while (chars_sent < target) begin
            w = $urandom_range(0, WordCount - 1);
            r = $urandom_range(0, 99);
            if (r < 60) begin
               send_word_part(w, reply_words[w].len(), $urandom_range(0, 3) == 0, -1);
            end else if (r < 75) begin
               send_word_part(w, $urandom_range(1, reply_words[w].len() - 1),
                              $urandom_range(0, 3) == 0, -1);
            end else if (r < 90) begin
               for (n = $urandom_range(1, 4); n > 0; n--) begin
                  send_char(char_type'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
               end
            end else begin
               send_word_part(w, reply_words[w].len(), $urandom_range(0, 1) == 1,
                              $urandom_range(0, reply_words[w].len() - 1));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_hold   <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mrm_result_type want;
      mrm_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.matched    = rsp_tdata[0];
         got.reply_code = rsp_tdata[CodeW:1];
         if (expected_replies.size() == 0) begin
            $error("Result transfer with nothing expected: rsp_tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (got.matched !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, got.matched);
               error_count++;
            end
            if (got.reply_code !== want.reply_code) begin
               $error("reply_code: expected %0d, actual %0d", want.reply_code,
                      got.reply_code);
               error_count++;
            end
            if (want.matched) begin
               replies_seen[want.reply_code]++;
               replies_total++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int w;
      for (w = 0; w < WordCount; w++) begin
         word_progress[w] = '0;
         replies_seen[w]  = 0;
      end
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_each_reply_word();
      test_naive_restart();
      test_clear_mid_word();
      test_byte_extremes();
      test_random_stream();

      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d characters; %0d reply words recognised.", chars_sent, replies_total);
      $display("OK %0d, ready %0d, FAIL %0d, no change %0d.", replies_seen[CODE_OK],
               replies_seen[CODE_READY], replies_seen[CODE_FAIL], replies_seen[CODE_NO_CHANGE]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mrm_pkg.sv
hw/rtl/mrm_match_core.sv
hw/rtl/modem_response_matcher_top.sv
dv/tb_top.sv
